>>> rtl/core/hbt_pkg.sv
package hbt_pkg;

    localparam int BYTE_W          = 8;
    localparam int FIELD_W         = 12;
    localparam int CFG_W           = 12;
    localparam int CFG_IDX_W       = 1;
    localparam int LENGTH_BITS_DEF = 12;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_VERB_MAX_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_MAX_LEN = 1'd1;

    localparam logic [CFG_W-1:0] VERB_MAX_LEN_RST = 12'd63;
    localparam logic [CFG_W-1:0] LINE_MAX_LEN_RST = 12'd1023;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        K_SKIP      = 3'd0,
        K_VERB_CHAR = 3'd1,
        K_KEY_CHAR  = 3'd2,
        K_SEPARATOR = 3'd3,
        K_VAL_CHAR  = 3'd4,
        K_LINE_END  = 3'd5,
        K_MSG_END   = 3'd6,
        K_ERROR     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE     = 2'd0,
        E_TOO_LONG = 2'd1,
        E_NO_COLON = 2'd2,
        E_ZERO     = 2'd3
    } t_err;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_nl;
        logic              is_zero;
        logic              is_colon;
        logic              is_lead_ws;
        logic              is_space;
        logic              is_trim;
    } t_byte_cls;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  out_byte;
        logic [FIELD_W-1:0] field_index;
        logic [FIELD_W-1:0] first_length;
        logic [FIELD_W-1:0] second_length;
        logic               line_is_verb;
        t_err               error_code;
    } t_result;

endpackage

>>> rtl/core/hbt_if.sv
interface hbt_byte_if import hbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface hbt_res_if import hbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [FIELD_W-1:0] field_index;
    logic [FIELD_W-1:0] first_length;
    logic [FIELD_W-1:0] second_length;
    logic               line_is_verb;
    logic [1:0]         error_code;

    modport source (output valid, output kind, output out_byte, output field_index,
                    output first_length, output second_length, output line_is_verb,
                    output error_code, input ready);
    modport sink (input valid, input kind, input out_byte, input field_index,
                  input first_length, input second_length, input line_is_verb,
                  input error_code, output ready);
endinterface

interface hbt_cfg_if import hbt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/header_block_tokenizer.sv
// Channel   Direction  Content
// i_in      sink       data_byte, one message byte per transaction
// o_out     source     kind, out_byte, field_index, lengths, line_is_verb, error_code
// i_cfg     sink       index and data of a register write, always ready
//
// One result transaction per input byte; a byte is taken every cycle while the
// four-entry classification queue has room. The tokenizer state lives in the back
// stage, which steps once per cycle while an item is queued and the output register
// has room. Reset is synchronous and returns the block to the start of a verb line.
// Either side may stall alone: the queue and the output register absorb the difference.
module header_block_tokenizer import hbt_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    hbt_byte_if.sink   i_in,
    hbt_res_if.source  o_out,
    hbt_cfg_if.sink    i_cfg
);

    logic [CFG_W-1:0] r_verb_max_len;
    logic [CFG_W-1:0] r_line_max_len;

    logic      push;
    logic      full;
    logic      pop;
    logic      q_valid;
    t_byte_cls cls_in;
    t_byte_cls cls_out;
    t_result   res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verb_max_len <= VERB_MAX_LEN_RST;
            r_line_max_len <= LINE_MAX_LEN_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_VERB_MAX_LEN) begin
                r_verb_max_len <= i_cfg.data;
            end
            if (i_cfg.index == REG_LINE_MAX_LEN) begin
                r_line_max_len <= i_cfg.data;
            end
        end
    end

    hbt_front u_front (
        .i_valid (i_in.valid),
        .i_data  (i_in.data_byte),
        .o_ready (i_in.ready),
        .o_push  (push),
        .o_cls   (cls_in),
        .i_full  (full)
    );

    hbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (cls_out),
        .o_valid (q_valid)
    );

    hbt_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_verb_max_len (r_verb_max_len),
        .i_line_max_len (r_line_max_len),
        .i_item_valid   (q_valid),
        .i_item         (cls_out),
        .o_pop          (pop),
        .o_res_valid    (o_out.valid),
        .o_res          (res),
        .i_res_ready    (o_out.ready)
    );

    assign o_out.kind          = res.kind;
    assign o_out.out_byte      = res.out_byte;
    assign o_out.field_index   = res.field_index;
    assign o_out.first_length  = res.first_length;
    assign o_out.second_length = res.second_length;
    assign o_out.line_is_verb  = res.line_is_verb;
    assign o_out.error_code    = res.error_code;

endmodule

>>> rtl/core/hbt_front.sv
module hbt_front import hbt_pkg::*; (
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_push,
    output t_byte_cls         o_cls,
    input  logic              i_full
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cls.data       = i_data;
        o_cls.is_nl      = (i_data == CH_NL);
        o_cls.is_zero    = (i_data == CH_NUL);
        o_cls.is_colon   = (i_data == CH_COLON);
        o_cls.is_space   = (i_data == CH_SPACE);
        o_cls.is_lead_ws = (i_data == CH_SPACE) || (i_data == CH_TAB);
        o_cls.is_trim    = (i_data == CH_SPACE) || (i_data == CH_TAB) || (i_data == CH_NL) ||
                           (i_data == CH_CR) || (i_data == CH_VT) || (i_data == CH_FF);
    end

endmodule

>>> rtl/core/hbt_queue.sv
module hbt_queue import hbt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_byte_cls i_data,
    output logic      o_full,
    input  logic      i_pop,
    output t_byte_cls o_data,
    output logic      o_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_byte_cls        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/hbt_back.sv
module hbt_back import hbt_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_verb_max_len,
    input  logic [CFG_W-1:0] i_line_max_len,
    input  logic             i_item_valid,
    input  t_byte_cls        i_item,
    output logic             o_pop,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    localparam int POS_W = LENGTH_BITS;
    localparam int CNT_W = LENGTH_BITS + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [5:0] {
        PH_VERB       = 6'b000001,
        PH_LINE_START = 6'b000010,
        PH_KEY        = 6'b000100,
        PH_VAL_LEAD   = 6'b001000,
        PH_VAL        = 6'b010000,
        PH_SKIP       = 6'b100000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_line_count, n_line_count;
    logic [POS_W-1:0] r_field_pos, n_field_pos;
    logic [POS_W-1:0] r_first_end, n_first_end;
    logic [POS_W-1:0] r_second_end, n_second_end;
    logic             r_leading_skip, n_leading_skip;
    logic             r_last_nl, n_last_nl;
    logic             r_res_valid;
    t_result          r_res, n_res;

    logic [CNT_W-1:0] lc_inc;
    logic [POS_W-1:0] fp_inc;
    logic             key_phase;

    assign o_pop       = i_item_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign lc_inc    = (&r_line_count) ? r_line_count : r_line_count + 1'b1;
    assign fp_inc    = (&r_field_pos) ? r_field_pos : r_field_pos + 1'b1;
    assign key_phase = (r_phase == PH_LINE_START) || (r_phase == PH_KEY);

    always_comb begin
        n_phase        = r_phase;
        n_line_count   = r_line_count;
        n_field_pos    = r_field_pos;
        n_first_end    = r_first_end;
        n_second_end   = r_second_end;
        n_leading_skip = r_leading_skip;
        n_last_nl      = r_last_nl;

        n_res               = '0;
        n_res.kind          = K_SKIP;
        n_res.error_code    = E_NONE;
        n_res.out_byte      = i_item.data;

        case (r_phase)
            PH_VERB: begin
                n_res.line_is_verb = 1'b1;
                if (i_item.is_nl) begin
                    n_res.kind         = K_LINE_END;
                    n_res.first_length = FIELD_W'(r_first_end);
                    n_line_count       = '0;
                    n_field_pos        = '0;
                    n_first_end        = '0;
                    n_second_end       = '0;
                    n_phase            = PH_LINE_START;
                end else if (i_item.is_zero) begin
                    n_res.kind       = K_ERROR;
                    n_res.error_code = E_ZERO;
                    n_phase          = PH_SKIP;
                    n_last_nl        = 1'b0;
                end else begin
                    if (CMP_W'(r_line_count) < CMP_W'(i_verb_max_len)) begin
                        if (!(r_leading_skip && i_item.is_space)) begin
                            n_leading_skip    = 1'b0;
                            n_res.kind        = K_VERB_CHAR;
                            n_res.field_index = FIELD_W'(r_field_pos);
                            n_field_pos       = fp_inc;
                            if (!i_item.is_trim) begin
                                n_first_end = fp_inc;
                            end
                        end
                    end
                    n_line_count = lc_inc;
                end
            end
            PH_LINE_START, PH_KEY, PH_VAL_LEAD, PH_VAL: begin
                if ((r_phase == PH_LINE_START) && (i_item.is_nl || i_item.is_zero)) begin
                    n_res.kind     = K_MSG_END;
                    n_phase        = PH_VERB;
                    n_line_count   = '0;
                    n_field_pos    = '0;
                    n_first_end    = '0;
                    n_second_end   = '0;
                    n_leading_skip = 1'b1;
                    n_last_nl      = 1'b0;
                end else begin
                    if (r_phase == PH_LINE_START) begin
                        n_phase = PH_KEY;
                    end
                    if (i_item.is_nl) begin
                        if (key_phase) begin
                            n_res.kind       = K_ERROR;
                            n_res.error_code = E_NO_COLON;
                            n_phase          = PH_SKIP;
                            n_last_nl        = 1'b1;
                        end else begin
                            n_res.kind          = K_LINE_END;
                            n_res.first_length  = FIELD_W'(r_first_end);
                            n_res.second_length = FIELD_W'(r_second_end);
                            n_line_count        = '0;
                            n_field_pos         = '0;
                            n_first_end         = '0;
                            n_second_end        = '0;
                            n_phase             = PH_LINE_START;
                        end
                    end else if (i_item.is_zero) begin
                        n_res.kind       = K_ERROR;
                        n_res.error_code = E_ZERO;
                        n_phase          = PH_SKIP;
                        n_last_nl        = 1'b0;
                    end else begin
                        n_line_count = lc_inc;
                        if (CMP_W'(lc_inc) > CMP_W'(i_line_max_len)) begin
                            n_res.kind       = K_ERROR;
                            n_res.error_code = E_TOO_LONG;
                            n_phase          = PH_SKIP;
                            n_last_nl        = 1'b0;
                        end else if (key_phase) begin
                            if (i_item.is_colon) begin
                                n_res.kind  = K_SEPARATOR;
                                n_field_pos = '0;
                                n_phase     = PH_VAL_LEAD;
                            end else begin
                                n_res.kind        = K_KEY_CHAR;
                                n_res.field_index = FIELD_W'(r_field_pos);
                                n_field_pos       = fp_inc;
                                if (!i_item.is_trim) begin
                                    n_first_end = fp_inc;
                                end
                            end
                        end else if ((r_phase == PH_VAL_LEAD) && i_item.is_lead_ws) begin
                            n_res.kind = K_SKIP;
                        end else begin
                            n_phase           = PH_VAL;
                            n_res.kind        = K_VAL_CHAR;
                            n_res.field_index = FIELD_W'(r_field_pos);
                            n_field_pos       = fp_inc;
                            if (!i_item.is_trim) begin
                                n_second_end = fp_inc;
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (i_item.is_nl && r_last_nl) begin
                    n_res.kind     = K_MSG_END;
                    n_phase        = PH_VERB;
                    n_line_count   = '0;
                    n_field_pos    = '0;
                    n_first_end    = '0;
                    n_second_end   = '0;
                    n_leading_skip = 1'b1;
                    n_last_nl      = 1'b0;
                end else begin
                    n_last_nl = i_item.is_nl;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_VERB;
            r_line_count   <= '0;
            r_field_pos    <= '0;
            r_first_end    <= '0;
            r_second_end   <= '0;
            r_leading_skip <= 1'b1;
            r_last_nl      <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase        <= n_phase;
                r_line_count   <= n_line_count;
                r_field_pos    <= n_field_pos;
                r_first_end    <= n_first_end;
                r_second_end   <= n_second_end;
                r_leading_skip <= n_leading_skip;
                r_last_nl      <= n_last_nl;
                r_res_valid    <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hbt_pkg::*;

    localparam int LB              = LENGTH_BITS_DEF;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 280;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [LB-1:0] POS_MAX = '1;
    localparam logic [LB:0]   CNT_MAX = '1;

    typedef enum logic [2:0] {
        SCAN_VERB,
        SCAN_LINE_START,
        SCAN_KEY,
        SCAN_VALUE_LEAD,
        SCAN_VALUE,
        SCAN_DISCARD
    } t_scan_phase;

    typedef struct {
        bit                   is_cfg;
        bit                   has_exp;
        logic [BYTE_W-1:0]    data;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_result              exp;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hbt_byte_if in_ch ();
    hbt_res_if  res_ch ();
    hbt_cfg_if  cfg_ch ();

    header_block_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_scan_phase      scan_phase;
    logic [LB:0]      line_len;
    logic [LB-1:0]    field_pos;
    logic [LB-1:0]    first_end;
    logic [LB-1:0]    second_end;
    logic             lead_skip;
    logic             prev_newline;
    logic [CFG_W-1:0] verb_max;
    logic [CFG_W-1:0] line_max;

    t_result           expected_results[$];
    t_step_row         directed_rows[$];
    logic [BYTE_W-1:0] byte_plan[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int tx_burst      = 0;
    int rx_burst      = 0;
    int rx_hold       = 0;
    bit pressure_done = 0;

    logic [CFG_W-1:0] verb_plan [PHASES] = '{12'd63, 12'd0, 12'd4095, 12'd3, 12'd0, 12'd1};
    logic [CFG_W-1:0] line_plan [PHASES] = '{12'd1023, 12'd0, 12'd4095, 12'd6, 12'd0, 12'd1};

    function automatic bit is_trim(logic [BYTE_W-1:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR ||
               b == CH_VT || b == CH_FF;
    endfunction

    function automatic void clear_line_state();
        line_len   = '0;
        field_pos  = '0;
        first_end  = '0;
        second_end = '0;
    endfunction

    function automatic void restart_message();
        scan_phase = SCAN_VERB;
        clear_line_state();
        lead_skip    = 1'b1;
        prev_newline = 1'b0;
    endfunction

    function automatic void start_discard(logic [BYTE_W-1:0] b);
        scan_phase   = SCAN_DISCARD;
        prev_newline = (b == CH_NL);
    endfunction

    function automatic logic [LB-1:0] claim_position();
        logic [LB-1:0] p;
        p = field_pos;
        if (field_pos < POS_MAX) field_pos = field_pos + 1'b1;
        return p;
    endfunction

    function automatic t_result tokenize_byte(logic [BYTE_W-1:0] b);
        t_result r;
        r = '0;
        r.out_byte = b;
        if (scan_phase == SCAN_VERB) begin
            r.line_is_verb = 1'b1;
            if (b == CH_NL) begin
                r.kind         = K_LINE_END;
                r.first_length = first_end;
                clear_line_state();
                scan_phase = SCAN_LINE_START;
            end else if (b == CH_NUL) begin
                r.kind       = K_ERROR;
                r.error_code = E_ZERO;
                start_discard(b);
            end else begin
                if (line_len < verb_max) begin
                    if (lead_skip && b == CH_SPACE) begin
                        r.kind = K_SKIP;
                    end else begin
                        lead_skip     = 1'b0;
                        r.kind        = K_VERB_CHAR;
                        r.field_index = claim_position();
                        if (!is_trim(b)) first_end = field_pos;
                    end
                end
                if (line_len < CNT_MAX) line_len = line_len + 1'b1;
            end
        end else if (scan_phase == SCAN_LINE_START && (b == CH_NL || b == CH_NUL)) begin
            r.kind = K_MSG_END;
            restart_message();
        end else if (scan_phase != SCAN_DISCARD) begin
            if (scan_phase == SCAN_LINE_START) scan_phase = SCAN_KEY;
            if (b == CH_NL) begin
                if (scan_phase == SCAN_KEY) begin
                    r.kind       = K_ERROR;
                    r.error_code = E_NO_COLON;
                    start_discard(b);
                end else begin
                    r.kind          = K_LINE_END;
                    r.first_length  = first_end;
                    r.second_length = second_end;
                    clear_line_state();
                    scan_phase = SCAN_LINE_START;
                end
            end else if (b == CH_NUL) begin
                r.kind       = K_ERROR;
                r.error_code = E_ZERO;
                start_discard(b);
            end else begin
                if (line_len < CNT_MAX) line_len = line_len + 1'b1;
                if (line_len > line_max) begin
                    r.kind       = K_ERROR;
                    r.error_code = E_TOO_LONG;
                    start_discard(b);
                end else if (scan_phase == SCAN_KEY) begin
                    if (b == CH_COLON) begin
                        r.kind     = K_SEPARATOR;
                        field_pos  = '0;
                        scan_phase = SCAN_VALUE_LEAD;
                    end else begin
                        r.kind        = K_KEY_CHAR;
                        r.field_index = claim_position();
                        if (!is_trim(b)) first_end = field_pos;
                    end
                end else if (scan_phase == SCAN_VALUE_LEAD && (b == CH_SPACE || b == CH_TAB)) begin
                    r.kind = K_SKIP;
                end else begin
                    scan_phase    = SCAN_VALUE;
                    r.kind        = K_VAL_CHAR;
                    r.field_index = claim_position();
                    if (!is_trim(b)) second_end = field_pos;
                end
            end
        end else begin
            if (b == CH_NL && prev_newline) begin
                r.kind = K_MSG_END;
                restart_message();
            end else begin
                r.kind       = K_SKIP;
                prev_newline = (b == CH_NL);
            end
        end
        return r;
    endfunction

    function automatic string describe(t_result r);
        return $sformatf("kind=%0d byte=%02h index=%0d first=%0d second=%0d verb=%0b error=%0d",
                         r.kind, r.out_byte, r.field_index, r.first_length, r.second_length,
                         r.line_is_verb, r.error_code);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0d] %s", cycle_count, msg);
    endfunction

    function automatic int pick_idle(inout int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic void add_byte(logic [BYTE_W-1:0] b);
        t_step_row row;
        row         = '{default: '0};
        row.data    = b;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(logic [BYTE_W-1:0] b, t_kind k, bit verb, t_err e);
        t_step_row row;
        row                  = '{default: '0};
        row.data             = b;
        row.has_exp          = 1'b1;
        row.exp              = '0;
        row.exp.kind         = k;
        row.exp.out_byte     = b;
        row.exp.line_is_verb = verb;
        row.exp.error_code   = e;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_step_row row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte(bit allow_colon);
        logic [BYTE_W-1:0] b;
        int r;
        do begin
            r = $urandom_range(0, 99);
            if (r < 70)      b = 8'($urandom_range(33, 126));
            else if (r < 80) b = CH_SPACE;
            else if (r < 85) b = CH_TAB;
            else if (r < 87) b = CH_CR;
            else if (r < 89) b = CH_VT;
            else if (r < 90) b = CH_FF;
            else             b = 8'($urandom_range(1, 255));
        end while (b == CH_NL || b == CH_NUL || (!allow_colon && b == CH_COLON));
        return b;
    endfunction

    function automatic void plan_header();
        int flaw;
        int n;
        flaw = $urandom_range(0, 99);
        n = $urandom_range(0, 6);
        repeat (n) byte_plan.push_back(text_byte(1'b0));
        if (flaw < 6) begin
            byte_plan.push_back(CH_NL);
            return;
        end
        if (flaw < 10) begin
            byte_plan.push_back(CH_NUL);
            byte_plan.push_back(CH_NL);
            return;
        end
        byte_plan.push_back(CH_COLON);
        repeat ($urandom_range(0, 3)) byte_plan.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        n = (flaw < 16) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        repeat (n) byte_plan.push_back(text_byte(1'b1));
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
                0:       byte_plan.push_back(CH_SPACE);
                1:       byte_plan.push_back(CH_TAB);
                2:       byte_plan.push_back(CH_CR);
                3:       byte_plan.push_back(CH_VT);
                default: byte_plan.push_back(CH_FF);
            endcase
        end
        byte_plan.push_back(CH_NL);
    endfunction

    function automatic void plan_message();
        int n;
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(3, 20);
            repeat (n) byte_plan.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
                byte_plan.push_back(CH_NL);
                byte_plan.push_back(CH_NL);
            end
            return;
        end
        repeat ($urandom_range(0, 3)) byte_plan.push_back(CH_SPACE);
        n = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 80) : $urandom_range(1, 8);
        repeat (n) byte_plan.push_back(text_byte(1'b1));
        if ($urandom_range(0, 3) == 0) byte_plan.push_back(CH_CR);
        byte_plan.push_back(CH_NL);
        repeat ($urandom_range(0, 4)) plan_header();
        byte_plan.push_back(($urandom_range(0, 19) == 0) ? CH_NUL : CH_NL);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit has_exp, input t_result typed);
        int gap;
        t_result pred;
        gap = pick_idle(tx_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pred = tokenize_byte(b);
        expected_results.push_back(has_exp ? typed : pred);
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        if (idx == REG_VERB_MAX_LEN) verb_max = val;
        else                         line_max = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL header_block_tokenizer");
        $finish;
    end

    // The receiver holds off once for a long stretch so that the block fills up and
    // the sender sees its input transactions stall.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                rx_hold       = PRESSURE_CYCLES;
            end
            if (rx_hold == 0) rx_hold = pick_idle(rx_burst);
            if (rx_hold > 0) begin
                res_ch.ready <= 1'b0;
                rx_hold--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.kind          = t_kind'(res_ch.kind);
            got.out_byte      = res_ch.out_byte;
            got.field_index   = res_ch.field_index;
            got.first_length  = res_ch.first_length;
            got.second_length = res_ch.second_length;
            got.line_is_verb  = res_ch.line_is_verb;
            got.error_code    = t_err'(res_ch.error_code);
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", describe(got)));
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    note_failure($sformatf("mismatch: expected %s, got %s",
                                           describe(want), describe(got)));
                end
            end
        end
    end

    initial begin
        int phase_start;
        t_result none;
        none = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        i_rst_n          = 1'b0;
        verb_max         = VERB_MAX_LEN_RST;
        line_max         = LINE_MAX_LEN_RST;
        restart_message();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_checked(CH_NUL, K_ERROR, 1'b1, E_ZERO);
        add_byte(CH_NL);
        add_checked(CH_NL, K_MSG_END, 1'b0, E_NONE);
        add_byte(CH_SPACE);
        add_byte("G");
        add_byte("T");
        add_byte(CH_SPACE);
        add_byte(CH_NL);
        add_byte("K");
        add_byte(CH_COLON);
        add_byte(CH_TAB);
        add_byte("v");
        add_byte(8'hFF);
        add_byte(CH_CR);
        add_byte(CH_NL);
        add_checked(CH_NUL, K_MSG_END, 1'b0, E_NONE);
        add_byte(CH_NL);
        add_byte("x");
        add_checked(CH_NL, K_ERROR, 1'b0, E_NO_COLON);
        add_checked(CH_NL, K_MSG_END, 1'b0, E_NONE);
        add_cfg(REG_VERB_MAX_LEN, 12'd0);
        add_cfg(REG_LINE_MAX_LEN, 12'd2);
        add_checked("a", K_SKIP, 1'b1, E_NONE);
        add_byte(CH_NL);
        add_byte("a");
        add_byte("b");
        add_checked("c", K_ERROR, 1'b0, E_TOO_LONG);
        add_byte(CH_NL);
        add_checked(CH_NL, K_MSG_END, 1'b0, E_NONE);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_byte(directed_rows[i].data, directed_rows[i].has_exp, directed_rows[i].exp);
            end
        end
        drain();

        verb_plan[4] = 12'($urandom_range(0, 12));
        line_plan[4] = 12'($urandom_range(0, 24));
        for (int p = 0; p < PHASES; p++) begin
            cfg_write(REG_VERB_MAX_LEN, verb_plan[p]);
            cfg_write(REG_LINE_MAX_LEN, line_plan[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                plan_message();
                while (byte_plan.size() != 0) send_byte(byte_plan.pop_front(), 1'b0, none);
            end
            drain();
        end

        if (expected_results.size() != 0) note_failure("results still expected at end of run");
        if (fail_count == 0) begin
            $display("PASS header_block_tokenizer");
        end else begin
            $display("FAIL header_block_tokenizer");
        end
        $finish;
    end

endmodule
